// ===== src/mcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mcrs_pkg - shared types and constants of the rank-sum sorter
// Beat types for the entry and result channels, and field widths.
// ----------------------------------------------------------------------------
package mcrs_pkg;

  localparam int NCRIT      = 4;
  localparam int FIELD_W    = 32;
  localparam int RANK_W     = 6;
  localparam int IDX_W      = 6;
  localparam int TOTAL_W    = 8;
  localparam int MASK_W     = 4;
  localparam logic [MASK_W-1:0] MASK_RESET = 4'd5;

  typedef struct packed {
    logic signed [FIELD_W-1:0] crit_a;
    logic signed [FIELD_W-1:0] crit_b;
    logic signed [FIELD_W-1:0] crit_c;
    logic signed [FIELD_W-1:0] crit_d;
    logic                      last_entry;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]   entry_index;
    logic [RANK_W-1:0]  rank_a;
    logic [RANK_W-1:0]  rank_b;
    logic [RANK_W-1:0]  rank_c;
    logic [RANK_W-1:0]  rank_d;
    logic [TOTAL_W-1:0] total_score;
    logic               overflow;
    logic               last_result;
  } out_beat_t;

endpackage

// ===== src/multi_criteria_rank_sum_sorter_core.sv =====
// ----------------------------------------------------------------------------
// multi_criteria_rank_sum_sorter_core - dense rank, rank sum and ordering
// Collects a set of entries, ranks four criteria, sorts by total, emits.
// ----------------------------------------------------------------------------
// Entries load at one beat per cycle until a beat with last_entry set; up to
// MAX_ITEMS are stored, later ones are dropped and flag overflow on every
// result of the set. After the last beat the input stalls while a sequencer
// drives one shared compare unit over the value RAMs: a duplicate pass, a
// dense rank pass, an exchange sort on the totals and an emit pass that
// holds each result through any output stall. The passes are paced by the
// single read port of each RAM with registered read data: a compare waits
// for its read data; the sort reads the order entry before its rank word.
// descending_mask bit k set makes a larger value best for criterion k; write
// it only while the block is idle.
// ----------------------------------------------------------------------------
module multi_criteria_rank_sum_sorter_core #(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mcrs_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mcrs_pkg::out_beat_t         out_data,
  input  logic                        cfg_wr_en,
  input  logic [mcrs_pkg::MASK_W-1:0] cfg_wr_data
);

  import mcrs_pkg::*;

  localparam int KW   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int AW   = $clog2(MAX_ITEMS);
  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int RK_W = NCRIT * RANK_W + TOTAL_W;

  typedef enum logic [20:0] {
    ST_IDLE   = 21'h000001,
    ST_DP_ISS = 21'h000002,
    ST_DP_PIV = 21'h000004,
    ST_DP_QI  = 21'h000008,
    ST_DP_QC  = 21'h000010,
    ST_DP_WR  = 21'h000020,
    ST_RK_ISS = 21'h000040,
    ST_RK_PIV = 21'h000080,
    ST_RK_QI  = 21'h000100,
    ST_RK_QC  = 21'h000200,
    ST_RK_WR  = 21'h000400,
    ST_SR_ISS = 21'h000800,
    ST_SR_OI  = 21'h001000,
    ST_SR_TI  = 21'h002000,
    ST_SR_JI  = 21'h004000,
    ST_SR_OJ  = 21'h008000,
    ST_SR_CMP = 21'h010000,
    ST_SR_WI  = 21'h020000,
    ST_EM_ISS = 21'h040000,
    ST_EM_OE  = 21'h080000,
    ST_EM_RK  = 21'h100000
  } state_t;

  // emit also needs a result hold state
  logic em_wait_r, em_wait_nxt;

  state_t                state_r, state_nxt;
  logic [MASK_W-1:0]     mask_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  drop_r, drop_nxt;
  logic [AW-1:0]         o_r, o_nxt;
  logic [AW-1:0]         q_r, q_nxt;
  logic [AW-1:0]         last_idx;
  logic [NCRIT-1:0][KW-1:0] piv_r, piv_nxt;
  logic [NCRIT-1:0]      flags_r, flags_nxt;
  logic [NCRIT-1:0][RANK_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]         oi_r, oi_nxt;
  logic [AW-1:0]         oj_r, oj_nxt;
  logic [TOTAL_W-1:0]    ti_r, ti_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_r, out_nxt;

  logic                  in_acc;
  logic                  room;
  logic [NCRIT-1:0][FIELD_W-1:0] raw;
  logic [NCRIT-1:0][KW-1:0] key_in;
  logic [NCRIT-1:0][KW-1:0] val_rd;
  logic [AW-1:0]         val_raddr;
  logic [NCRIT-1:0]      first_rd;
  logic                  first_we;
  logic [RK_W-1:0]       rank_rd, rank_wd;
  logic                  rank_we;
  logic [AW-1:0]         ord_rd, ord_raddr, ord_waddr, ord_wd;
  logic                  ord_we;
  logic [NCRIT-1:0]      eq, bet;
  logic [TOTAL_W-1:0]    total_sum;
  logic [TOTAL_W-1:0]    tj;

  assign in_stall  = (state_r != ST_IDLE) || em_wait_r;
  assign in_acc    = in_valid && !in_stall;
  assign room      = (count_r < CW'(MAX_ITEMS));
  assign last_idx  = AW'(count_r - CW'(1));
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // map each field to an offset-binary key of KW bits
  assign raw = {in_data.crit_d, in_data.crit_c, in_data.crit_b, in_data.crit_a};
  always_comb begin
    for (int c = 0; c < NCRIT; c++) begin
      key_in[c] = raw[c][KW-1:0] ^ {1'b1, {(KW-1){1'b0}}};
    end
  end

  assign val_raddr = ((state_r == ST_DP_ISS) || (state_r == ST_RK_ISS)) ? o_r : q_r;

  for (genvar c = 0; c < NCRIT; c++) begin : g_val
    mcrs_ram #(.WIDTH(KW), .DEPTH(MAX_ITEMS)) u_val (
      .clk   (clk),
      .we    (in_acc && room),
      .waddr (count_r[AW-1:0]),
      .wdata (key_in[c]),
      .raddr (val_raddr),
      .rdata (val_rd[c])
    );
  end

  // first-occurrence flags per entry and criterion
  assign first_we = (state_r == ST_DP_WR);
  mcrs_ram #(.WIDTH(NCRIT), .DEPTH(MAX_ITEMS)) u_first (
    .clk   (clk),
    .we    (first_we),
    .waddr (o_r),
    .wdata (flags_r),
    .raddr (q_r),
    .rdata (first_rd)
  );

  assign total_sum = TOTAL_W'(cnt_r[0]) + TOTAL_W'(cnt_r[1])
                   + TOTAL_W'(cnt_r[2]) + TOTAL_W'(cnt_r[3]);
  assign rank_we   = (state_r == ST_RK_WR);
  assign rank_wd   = {total_sum, cnt_r[3], cnt_r[2], cnt_r[1], cnt_r[0]};
  assign tj        = rank_rd[RK_W-1 -: TOTAL_W];

  // rank word is always looked up through the entry just read from order
  mcrs_ram #(.WIDTH(RK_W), .DEPTH(MAX_ITEMS)) u_rank (
    .clk   (clk),
    .we    (rank_we),
    .waddr (o_r),
    .wdata (rank_wd),
    .raddr (ord_rd),
    .rdata (rank_rd)
  );

  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = o_r;
    ord_wd    = oi_r;
    case (state_r)
      ST_RK_WR: begin
        ord_we = 1'b1;
        ord_wd = o_r;
      end
      ST_SR_CMP: begin
        ord_we    = (ti_r > tj);
        ord_waddr = q_r;
      end
      ST_SR_WI: begin
        ord_we = 1'b1;
      end
      default: begin
        ord_we = 1'b0;
      end
    endcase
  end

  assign ord_raddr = (state_r == ST_SR_JI) ? q_r : o_r;

  mcrs_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_order (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wd),
    .raddr (ord_raddr),
    .rdata (ord_rd)
  );

  mcrs_cmp #(.KEY_W(KW)) u_cmp (
    .piv  (piv_r),
    .dat  (val_rd),
    .mask (mask_r),
    .eq   (eq),
    .bet  (bet)
  );

  always_comb begin
    state_nxt     = state_r;
    em_wait_nxt   = em_wait_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    o_nxt         = o_r;
    q_nxt         = q_r;
    piv_nxt       = piv_r;
    flags_nxt     = flags_r;
    cnt_nxt       = cnt_r;
    oi_nxt        = oi_r;
    oj_nxt        = oj_r;
    ti_nxt        = ti_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (em_wait_r) begin
      // hold the result until taken
      if (!out_stall) begin
        out_valid_nxt = 1'b0;
        em_wait_nxt   = 1'b0;
        if (o_r == last_idx) begin
          count_nxt = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          o_nxt     = o_r + AW'(1);
          state_nxt = ST_EM_ISS;
        end
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (room) begin
              count_nxt = count_r + CW'(1);
            end else begin
              drop_nxt = 1'b1;
            end
            if (in_data.last_entry) begin
              o_nxt     = '0;
              state_nxt = ST_DP_ISS;
            end
          end
        end
        ST_DP_ISS: state_nxt = ST_DP_PIV;
        ST_DP_PIV: begin
          piv_nxt   = val_rd;
          flags_nxt = '1;
          q_nxt     = '0;
          state_nxt = (o_r == '0) ? ST_DP_WR : ST_DP_QI;
        end
        ST_DP_QI: state_nxt = ST_DP_QC;
        ST_DP_QC: begin
          flags_nxt = flags_r & ~eq;
          if (q_r == o_r - AW'(1)) begin
            state_nxt = ST_DP_WR;
          end else begin
            q_nxt     = q_r + AW'(1);
            state_nxt = ST_DP_QI;
          end
        end
        ST_DP_WR: begin
          if (o_r == last_idx) begin
            o_nxt     = '0;
            state_nxt = ST_RK_ISS;
          end else begin
            o_nxt     = o_r + AW'(1);
            state_nxt = ST_DP_ISS;
          end
        end
        ST_RK_ISS: state_nxt = ST_RK_PIV;
        ST_RK_PIV: begin
          piv_nxt   = val_rd;
          cnt_nxt   = '0;
          q_nxt     = '0;
          state_nxt = ST_RK_QI;
        end
        ST_RK_QI: state_nxt = ST_RK_QC;
        ST_RK_QC: begin
          // count distinct better values: first occurrences only
          for (int c = 0; c < NCRIT; c++) begin
            if (first_rd[c] && bet[c]) begin
              cnt_nxt[c] = cnt_r[c] + RANK_W'(1);
            end
          end
          if (q_r == last_idx) begin
            state_nxt = ST_RK_WR;
          end else begin
            q_nxt     = q_r + AW'(1);
            state_nxt = ST_RK_QI;
          end
        end
        ST_RK_WR: begin
          if (o_r == last_idx) begin
            o_nxt     = '0;
            state_nxt = (last_idx == '0) ? ST_EM_ISS : ST_SR_ISS;
          end else begin
            o_nxt     = o_r + AW'(1);
            state_nxt = ST_RK_ISS;
          end
        end
        ST_SR_ISS: state_nxt = ST_SR_OI;
        ST_SR_OI: begin
          oi_nxt    = ord_rd;
          state_nxt = ST_SR_TI;
        end
        ST_SR_TI: begin
          ti_nxt    = tj;
          q_nxt     = o_r + AW'(1);
          state_nxt = ST_SR_JI;
        end
        ST_SR_JI: state_nxt = ST_SR_OJ;
        ST_SR_OJ: begin
          oj_nxt    = ord_rd;
          state_nxt = ST_SR_CMP;
        end
        ST_SR_CMP: begin
          // swap: old head goes to j, j becomes the new head
          if (ti_r > tj) begin
            oi_nxt = oj_r;
            ti_nxt = tj;
          end
          if (q_r == last_idx) begin
            state_nxt = ST_SR_WI;
          end else begin
            q_nxt     = q_r + AW'(1);
            state_nxt = ST_SR_JI;
          end
        end
        ST_SR_WI: begin
          if (o_r == last_idx - AW'(1)) begin
            o_nxt     = '0;
            state_nxt = ST_EM_ISS;
          end else begin
            o_nxt     = o_r + AW'(1);
            state_nxt = ST_SR_ISS;
          end
        end
        ST_EM_ISS: state_nxt = ST_EM_OE;
        ST_EM_OE: begin
          // rank word arrives next cycle; build the beat then
          oj_nxt    = ord_rd;
          state_nxt = ST_EM_RK;
        end
        ST_EM_RK: begin
          out_nxt.entry_index = IDX_W'(oj_r);
          out_nxt.rank_a      = rank_rd[0 +: RANK_W];
          out_nxt.rank_b      = rank_rd[RANK_W +: RANK_W];
          out_nxt.rank_c      = rank_rd[2*RANK_W +: RANK_W];
          out_nxt.rank_d      = rank_rd[3*RANK_W +: RANK_W];
          out_nxt.total_score = tj;
          out_nxt.overflow    = drop_r;
          out_nxt.last_result = (o_r == last_idx);
          out_valid_nxt       = 1'b1;
          em_wait_nxt         = 1'b1;
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      em_wait_r   <= 1'b0;
      mask_r      <= MASK_RESET;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      o_r         <= '0;
      q_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
      state_r     <= state_nxt;
      em_wait_r   <= em_wait_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      o_r         <= o_nxt;
      q_r         <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    piv_r   <= piv_nxt;
    flags_r <= flags_nxt;
    cnt_r   <= cnt_nxt;
    oi_r    <= oi_nxt;
    oj_r    <= oj_nxt;
    ti_r    <= ti_nxt;
    out_r   <= out_nxt;
  end

endmodule

// ===== src/mcrs_ram.sv =====
// ----------------------------------------------------------------------------
// mcrs_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mcrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mcrs_cmp.sv =====
// ----------------------------------------------------------------------------
// mcrs_cmp - shared key compare unit
// Equality and "better than" of one stored key row against the pivot row.
// ----------------------------------------------------------------------------
module mcrs_cmp #(
  parameter int KEY_W = 32
) (
  input  logic [mcrs_pkg::NCRIT-1:0][KEY_W-1:0] piv,
  input  logic [mcrs_pkg::NCRIT-1:0][KEY_W-1:0] dat,
  input  logic [mcrs_pkg::MASK_W-1:0]           mask,
  output logic [mcrs_pkg::NCRIT-1:0]            eq,
  output logic [mcrs_pkg::NCRIT-1:0]            bet
);

  import mcrs_pkg::*;

  // keys are offset binary, so unsigned compare gives signed order
  always_comb begin
    for (int c = 0; c < NCRIT; c++) begin
      eq[c]  = (dat[c] == piv[c]);
      bet[c] = mask[c] ? (dat[c] > piv[c]) : (dat[c] < piv[c]);
    end
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - rank-sum sorter scoreboard test
// Drives entry sets through the core under random idling on both channels,
// predicts dense ranks, totals and the exchange-sort order for each set, and
// compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mcrs_pkg::*;

  localparam int CAP = 64;

  // Scoreboard: holds the current set and the queue of predicted result beats.
  class rank_scoreboard;
    logic signed [FIELD_W-1:0] vals [CAP][NCRIT];
    int                        held;
    bit                        dropped;
    logic [MASK_W-1:0]         dmask;
    out_beat_t                 pending [$];
    int                        mismatches;
    int                        beats_seen;

    function new();
      held = 0;
      dropped = 0;
      dmask = MASK_RESET;
      mismatches = 0;
      beats_seen = 0;
    endfunction

    function int dense_rank(int e, int c);
      int r;
      bit seen;
      logic signed [FIELD_W-1:0] vj;
      r = 0;
      for (int j = 0; j < held; j++) begin
        vj = vals[j][c];
        if (dmask[c] ? (vj > vals[e][c]) : (vj < vals[e][c])) begin
          seen = 0;
          for (int k = 0; k < j; k++) if (vals[k][c] == vj) seen = 1;
          if (!seen) r++;
        end
      end
      return r;
    endfunction

    function void note_entry(in_beat_t b);
      int ranks [CAP][NCRIT];
      int tot [CAP];
      int ord [CAP];
      int t;
      out_beat_t o;
      if (held < CAP) begin
        vals[held][0] = b.crit_a;
        vals[held][1] = b.crit_b;
        vals[held][2] = b.crit_c;
        vals[held][3] = b.crit_d;
        held++;
      end else begin
        dropped = 1;
      end
      if (!b.last_entry) return;
      for (int i = 0; i < held; i++) begin
        tot[i] = 0;
        for (int c = 0; c < NCRIT; c++) begin
          ranks[i][c] = dense_rank(i, c);
          tot[i] += ranks[i][c];
        end
        ord[i] = i;
      end
      for (int i = 0; i + 1 < held; i++)
        for (int j = i + 1; j < held; j++)
          if (tot[ord[i]] > tot[ord[j]]) begin
            t = ord[i];
            ord[i] = ord[j];
            ord[j] = t;
          end
      for (int i = 0; i < held; i++) begin
        o.entry_index = IDX_W'(ord[i]);
        o.rank_a = RANK_W'(ranks[ord[i]][0]);
        o.rank_b = RANK_W'(ranks[ord[i]][1]);
        o.rank_c = RANK_W'(ranks[ord[i]][2]);
        o.rank_d = RANK_W'(ranks[ord[i]][3]);
        o.total_score = TOTAL_W'(tot[ord[i]]);
        o.overflow = dropped;
        o.last_result = (i + 1 == held);
        pending.insert(pending.size(), o);
      end
      held = 0;
      dropped = 0;
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      beats_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  logic      cfg_wr_en;
  logic [MASK_W-1:0] cfg_wr_data;

  rank_scoreboard sb;
  int sets_sent;
  int beats_sent;

  multi_criteria_rank_sum_sorter_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Pick a criterion value: mostly a narrow pool so ties and shared ranks
  // are common, sometimes extremes or full-range random.
  function automatic logic signed [FIELD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return $urandom();
      default: return $signed($urandom_range(0, 6)) - 3;
    endcase
  endfunction

  // Send one entry beat; hold it until accepted, then note it. Valid stays
  // high after the accepting edge; drop it here on a gap or in drain().
  task automatic send_entry(in_beat_t b);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_entry(b);
    beats_sent++;
    if (b.last_entry) sets_sent++;
  endtask

  task automatic send_set(int n, bit extreme);
    in_beat_t b;
    for (int i = 0; i < n; i++) begin
      if (extreme) begin
        b.crit_a = (i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
        b.crit_b = (i % 3 == 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        b.crit_c = 0;
        b.crit_d = (i % 2) ? -1 : 32'sh8000_0000;
      end else begin
        b.crit_a = pick_value();
        b.crit_b = pick_value();
        b.crit_c = pick_value();
        b.crit_d = pick_value();
      end
      b.last_entry = (i == n - 1);
      send_entry(b);
    end
  endtask

  // Drop valid, wait for every predicted beat, then pad for the block to settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_mask(logic [MASK_W-1:0] m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.dmask = m;
  endtask

  // Receiver: draw a stall length per beat, sample at the edge.
  initial begin
    int gap;
    out_stall = 1'b1;
    gap = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
      if (gap > 0) begin
        gap--;
        out_stall <= 1'b1;
      end else begin
        if (out_valid && !out_stall) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
        out_stall <= (gap > 0);
      end
    end
  end

  // Hard stop on a hang.
  initial begin
    #4ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int n;
    sb = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    sets_sent   = 0;
    beats_sent  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-entry set, extreme values, all-ones and all-zeros masks.
    send_set(1, 1);
    send_set(5, 1);
    write_mask(4'hF);
    send_set(4, 1);
    write_mask(4'h0);
    send_set(6, 0);
    // Pause the sender until the results are all back.
    drain();
    send_set(3, 0);

    // Random sets, mostly small; one overfull set to exercise dropping.
    while (beats_sent < 340) begin
      if ($urandom_range(0, 4) == 0) write_mask(MASK_W'($urandom_range(0, 15)));
      if (beats_sent >= 200 && beats_sent < 240) n = 70;
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(20, 40);
      else n = $urandom_range(1, 10);
      send_set(n, 0);
    end
    write_mask(MASK_RESET);
    send_set(CAP, 0);
    drain();

    $display("covered %0d entry beats in %0d sets, %0d result beats checked",
             beats_sent, sets_sent, sb.beats_seen);
    $display("%0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== multi_criteria_rank_sum_sorter_core.f =====
src/mcrs_pkg.sv
src/mcrs_ram.sv
src/mcrs_cmp.sv
src/multi_criteria_rank_sum_sorter_core.sv
test/testbench.sv
